>>> src/swfd_pkg.sv
// Package for the sliding window frame deframer: window geometry, frame markers,
// header strings and the structs passed between the window, decode and result blocks.
// No dependencies.
package swfd_pkg;

    // Window geometry and frame markers
    localparam int unsigned WIN_LEN              = 32;
    localparam int unsigned FILL_W               = 6;
    localparam int unsigned END_POS              = 31;
    localparam int unsigned HDR_LEN              = 9;
    localparam int unsigned TAG_POS              = 9;
    localparam int unsigned BODY_POS             = 10;
    localparam int unsigned TAG_LIMIT            = 8;
    localparam int unsigned ACTION_CODE_BYTES_DEF = 8;
    localparam int unsigned TEXT_W               = 64;
    localparam int unsigned LEN_W                = 4;

    localparam logic [7:0] END_MARK = 8'hED;
    localparam logic [7:0] ACT_TAG  = 8'h0F;
    localparam logic [7:0] DASH     = 8'h2D;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_LEN);

    // Frame kind codes
    localparam logic KIND_MEAS = 1'b0;
    localparam logic KIND_ACT  = 1'b1;

    // Header strings, first byte at index 0
    localparam logic [7:0] HDR_MEAS [HDR_LEN] = '{
        8'h4D, 8'h45, 8'h41, 8'h53, 8'h55, 8'h52, 8'h49, 8'h4E, 8'h47
    };
    localparam logic [7:0] HDR_ACT [HDR_LEN] = '{
        8'h41, 8'h43, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h49, 8'h4E, 8'h47
    };

    // Window bytes, element 0 is the oldest byte
    typedef logic [WIN_LEN-1:0][7:0] window_t;

    // Frame check outcome
    typedef struct packed {
        logic       frame;       // valid frame, window is consumed
        logic       has_result;  // frame produces a result beat
        logic       is_meas;     // measuring frame
        logic [2:0] tag;         // measuring tag
    } dec_status_t;

    // Result payload without the sequence number
    typedef struct packed {
        logic              frame_kind;
        logic [2:0]        tag_index;
        logic [31:0]       pos_x_bits;
        logic [31:0]       pos_y_bits;
        logic [31:0]       bearing_bits;
        logic [31:0]       heading_bits;
        logic [31:0]       margin_bits;
        logic [TEXT_W-1:0] action_text;
        logic [LEN_W-1:0]  action_length;
        logic [7:0]        stage_pins;
    } result_t;

endpackage

>>> src/swfd_window.sv
// Byte window shift line, fill count and frame check scheduling.
// Depends on swfd_pkg.
module swfd_window (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_rx_byte,
    input  swfd_pkg::dec_status_t status,
    input  logic                  out_free,
    output swfd_pkg::window_t     window,
    output logic                  check_done
);

    swfd_pkg::window_t                win_reg;
    logic [swfd_pkg::FILL_W-1:0]      fill_reg;
    logic [swfd_pkg::FILL_W-1:0]      fill_next;
    logic                             pending_reg;
    logic                             pending_next;
    logic                             accept;

    // Finish a pending check unless its result has nowhere to go
    assign check_done = pending_reg && (out_free || !status.has_result);
    assign s_ready    = !pending_reg || check_done;
    assign accept     = s_valid && s_ready;
    assign window     = win_reg;

    // Empty on a consumed frame, then count the new beat
    always_comb begin
        fill_next    = fill_reg;
        pending_next = pending_reg && !check_done;
        if (check_done && status.frame) begin
            fill_next = '0;
        end
        if (accept) begin
            if (fill_next != swfd_pkg::FILL_FULL) begin
                fill_next = fill_next + swfd_pkg::FILL_W'(1);
            end
            pending_next = (fill_next == swfd_pkg::FILL_FULL);
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            pending_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            pending_reg <= pending_next;
        end
    end

    // Shift the new byte in at the top
    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg <= {s_rx_byte, win_reg[swfd_pkg::WIN_LEN-1:1]};
        end
    end

`ifndef ASSERT_OFF
    a_pending_full: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg |-> (fill_reg == swfd_pkg::FILL_FULL))
        else $error("check pending on a window that is not full");

    a_consume_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (check_done && status.frame && !accept) |=> (fill_reg == '0))
        else $error("consumed frame did not empty the window");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg && !check_done) |=> (pending_reg && $stable(win_reg)))
        else $error("stalled check lost its window");
`endif

endmodule

>>> src/swfd_decode.sv
// Frame check and field extraction on the current window.
// Depends on swfd_pkg.
module swfd_decode #(
    parameter int unsigned ACTION_CODE_BYTES = swfd_pkg::ACTION_CODE_BYTES_DEF
) (
    input  swfd_pkg::window_t     window,
    input  logic [2:0]            last_tag,
    input  logic                  tag_known,
    output swfd_pkg::dec_status_t status,
    output swfd_pkg::result_t     result
);

    logic                           meas_hdr;
    logic                           act_hdr;
    logic                           end_ok;
    logic                           meas;
    logic                           act;
    logic [7:0]                     tag_byte;
    logic [swfd_pkg::LEN_W-1:0]     len;
    logic [swfd_pkg::TEXT_W-1:0]    text;

    assign tag_byte = window[swfd_pkg::TAG_POS];
    assign end_ok   = (window[swfd_pkg::END_POS] == swfd_pkg::END_MARK);

    // Compare the header bytes
    always_comb begin
        meas_hdr = 1'b1;
        act_hdr  = 1'b1;
        for (int i = 0; i < swfd_pkg::HDR_LEN; i++) begin
            if (window[i] != swfd_pkg::HDR_MEAS[i]) meas_hdr = 1'b0;
            if (window[i] != swfd_pkg::HDR_ACT[i])  act_hdr  = 1'b0;
        end
    end

    assign meas = end_ok && meas_hdr;
    assign act  = end_ok && act_hdr;

    // Trim trailing dashes from the action code
    always_comb begin
        len = '0;
        for (int i = 0; i < ACTION_CODE_BYTES; i++) begin
            if (window[swfd_pkg::BODY_POS + i] != swfd_pkg::DASH) begin
                len = swfd_pkg::LEN_W'(i + 1);
            end
        end
    end

    // Keep code bytes below the trimmed length
    always_comb begin
        text = '0;
        for (int i = 0; i < ACTION_CODE_BYTES; i++) begin
            if (swfd_pkg::LEN_W'(i) < len) begin
                text[8*i +: 8] = window[swfd_pkg::BODY_POS + i];
            end
        end
    end

    always_comb begin
        status.frame      = meas || act;
        status.is_meas    = meas;
        status.tag        = tag_byte[2:0];
        status.has_result = (meas && (tag_byte < 8'(swfd_pkg::TAG_LIMIT)))
                         || (act && (tag_byte == swfd_pkg::ACT_TAG));
    end

    // Build the result fields for either frame kind
    always_comb begin
        result = '0;
        if (meas) begin
            result.frame_kind   = swfd_pkg::KIND_MEAS;
            result.tag_index    = tag_byte[2:0];
            result.pos_x_bits   = {window[13], window[12], window[11], window[10]};
            result.pos_y_bits   = {window[17], window[16], window[15], window[14]};
            result.bearing_bits = {window[21], window[20], window[19], window[18]};
            result.heading_bits = {window[25], window[24], window[23], window[22]};
            result.margin_bits  = {window[29], window[28], window[27], window[26]};
            result.stage_pins   = ~(8'b1 << tag_byte[2:0]);
        end else begin
            result.frame_kind    = swfd_pkg::KIND_ACT;
            result.tag_index     = last_tag;
            result.action_text   = text;
            result.action_length = len;
            result.stage_pins    = tag_known ? (8'b1 << last_tag) : 8'b0;
        end
    end

endmodule

>>> src/swfd_result.sv
// Result register, frame counter and remembered tag.
// Depends on swfd_pkg.
module swfd_result (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  check_done,
    input  swfd_pkg::dec_status_t status,
    input  swfd_pkg::result_t     result,
    output logic                  out_free,
    output logic [2:0]            last_tag,
    output logic                  tag_known,
    output logic                  m_valid,
    input  logic                  m_ready,
    output swfd_pkg::result_t     m_result,
    output logic [31:0]           m_sequence_number
);

    logic              m_valid_reg;
    swfd_pkg::result_t m_result_reg;
    logic [31:0]       m_seq_reg;
    logic [31:0]       counter_reg;
    logic [2:0]        last_tag_reg;
    logic              tag_known_reg;
    logic              load;

    assign out_free          = !m_valid_reg || m_ready;
    assign load              = check_done && status.has_result;
    assign m_valid           = m_valid_reg;
    assign m_result          = m_result_reg;
    assign m_sequence_number = m_seq_reg;
    assign last_tag          = last_tag_reg;
    assign tag_known         = tag_known_reg;

    // Advance counter and tag state, hold the output beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            counter_reg   <= '0;
            last_tag_reg  <= '0;
            tag_known_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                counter_reg <= counter_reg + 32'd1;
                if (status.is_meas) begin
                    last_tag_reg  <= status.tag;
                    tag_known_reg <= 1'b1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Load the payload
    always_ff @(posedge aclk) begin
        if (load) begin
            m_result_reg <= result;
            m_seq_reg    <= counter_reg + 32'd1;
        end
    end

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> out_free)
        else $error("result loaded over a beat not yet taken");

    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (m_seq_reg == counter_reg))
        else $error("sequence number does not match frame counter");

    a_tag_known: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && status.is_meas) |=> tag_known_reg)
        else $error("measuring frame did not record its tag");
`endif

endmodule

>>> src/sliding_window_frame_deframer.sv
// A frame's closing byte enters the window, then its result beat is registered.
// Throughput: one byte per cycle; a byte stalls only while a finished frame check
// waits for the result register, which is freed by the downstream handshake.
// Reset: synchronous active-low aresetn clears fill count, check flag, frame
// counter, tag state and output valid; window bytes are not reset.
// Top level: sliding window frame deframer. Depends on swfd_pkg and submodules.
module sliding_window_frame_deframer #(
    parameter int unsigned ACTION_CODE_BYTES = swfd_pkg::ACTION_CODE_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_rx_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_frame_kind,
    output logic [2:0]                   m_tag_index,
    output logic [31:0]                  m_pos_x_bits,
    output logic [31:0]                  m_pos_y_bits,
    output logic [31:0]                  m_bearing_bits,
    output logic [31:0]                  m_heading_bits,
    output logic [31:0]                  m_margin_bits,
    output logic [swfd_pkg::TEXT_W-1:0]  m_action_text,
    output logic [swfd_pkg::LEN_W-1:0]   m_action_length,
    output logic [7:0]                   m_stage_pins,
    output logic [31:0]                  m_sequence_number
);

    swfd_pkg::window_t     window;
    swfd_pkg::dec_status_t status;
    swfd_pkg::result_t     result;
    swfd_pkg::result_t     m_result;
    logic                  out_free;
    logic                  check_done;
    logic [2:0]            last_tag;
    logic                  tag_known;

    swfd_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .status     (status),
        .out_free   (out_free),
        .window     (window),
        .check_done (check_done)
    );

    swfd_decode #(
        .ACTION_CODE_BYTES (ACTION_CODE_BYTES)
    ) u_decode (
        .window    (window),
        .last_tag  (last_tag),
        .tag_known (tag_known),
        .status    (status),
        .result    (result)
    );

    swfd_result u_result (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .check_done        (check_done),
        .status            (status),
        .result            (result),
        .out_free          (out_free),
        .last_tag          (last_tag),
        .tag_known         (tag_known),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result          (m_result),
        .m_sequence_number (m_sequence_number)
    );

    // Unpack the result beat onto its ports
    assign m_frame_kind    = m_result.frame_kind;
    assign m_tag_index     = m_result.tag_index;
    assign m_pos_x_bits    = m_result.pos_x_bits;
    assign m_pos_y_bits    = m_result.pos_y_bits;
    assign m_bearing_bits  = m_result.bearing_bits;
    assign m_heading_bits  = m_result.heading_bits;
    assign m_margin_bits   = m_result.margin_bits;
    assign m_action_text   = m_result.action_text;
    assign m_action_length = m_result.action_length;
    assign m_stage_pins    = m_result.stage_pins;

endmodule
